### hw/rtl/dfsw_pkg.sv
// Shared types and constants for the depth-first search walker.
package dfsw_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int MAX_EDGES_DEF    = 1024;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [2:0] KIND_ACCEPTED   = 3'd0;
    localparam logic [2:0] KIND_REJECTED   = 3'd1;
    localparam logic [2:0] KIND_DISCOVERED = 3'd2;
    localparam logic [2:0] KIND_TREE_EDGE  = 3'd3;
    localparam logic [2:0] KIND_FINISHED   = 3'd4;
    localparam logic [2:0] KIND_DONE       = 3'd5;

    localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_CLEAR  = 10'b0000000010,
        ST_ADD    = 10'b0000000100,
        ST_DISC   = 10'b0000001000,
        ST_TOP    = 10'b0000010000,
        ST_EDGE   = 10'b0000100000,
        ST_SEEN   = 10'b0001000000,
        ST_OUT    = 10'b0010000000,
        ST_HEAD   = 10'b0100000000,
        ST_ADD2   = 10'b1000000000
    } state_t;

endpackage

### hw/rtl/depth_first_search_walker_top.sv
// Top level of the depth-first search walker: edge store, walk stack and sequencer.
//
// Depth-first search walker. Edges are loaded with add commands (cmd 0) and
// appended to their source vertex's list; a start command (cmd 1) arms a walk
// from from_vertex, and each step command (cmd 2) returns one event:
// discovered, tree edge (vertex = child, other_vertex = parent) or finished,
// and done once the walk has ended. Clear (cmd 3) empties the graph. One beat
// is processed at a time. An add reads the source list's head and tail, then
// writes the edge, and links the old tail to it when the list already holds
// edges. A discovered event reads the child's list head, then marks and pushes
// the child. A tree edge or finished event reads the stack top, then examines
// adjacency entries in turn, each by single-port reads of the edge memories and
// then of the discovered-mark memory; finished is returned once the cursor
// runs past the last entry. After reset, and after each clear command, a
// clearing pass sweeps the head/tail lists and the marks over all MAX_VERTICES
// entries before the block takes the next beat. Discovered marks use an epoch
// count, so a start normally costs no sweep; once every 255 starts the epoch
// wraps and a marks-only sweep over all MAX_VERTICES entries follows the start.
// The result sits in an output register, and the next beat is taken in the
// cycle after the result has been taken.
module depth_first_search_walker_top
    import dfsw_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] from_vertex, [15:8] to_vertex
    input  logic [15:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] vertex, [15:8] other_vertex
    output logic [15:0] m_tdata,
    // [2:0] kind
    output logic [2:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_EDGES + 1);   // link width incl. null
    localparam int AW = $clog2(MAX_EDGES);
    localparam int DW = $clog2(MAX_VERTICES + 1);
    localparam logic [EW-1:0] LINK_NULL = EW'(MAX_EDGES);

    // ---- memories ----
    logic [EW-1:0] head_mem   [MAX_VERTICES];
    logic [EW-1:0] tail_mem   [MAX_VERTICES];
    logic [EW-1:0] next_mem   [MAX_EDGES];
    logic [7:0]    target_mem [MAX_EDGES];
    logic [7:0]    stk_v_mem  [MAX_VERTICES];
    logic [EW-1:0] stk_c_mem  [MAX_VERTICES];
    logic [7:0]    epoch_mem  [MAX_VERTICES];   // mark = epoch match

    // ---- registers ----
    state_t        state_reg;
    logic [8:0]    vcount_reg;
    logic [EW-1:0] used_reg;
    logic [DW-1:0] depth_reg;
    logic          pend_reg;
    logic [7:0]    pend_v_reg;
    logic [7:0]    epoch_reg;
    logic [VW-1:0] sweep_reg;
    logic          sweep_all_reg;   // sweep lists too, not only marks
    logic [7:0]    from_reg, to_reg;
    logic [7:0]    top_v_reg;
    logic [EW-1:0] cur_reg;
    logic [7:0]    y_reg;
    logic          out_valid_reg;
    logic [2:0]    kind_reg;
    logic [7:0]    ov_reg, oo_reg;
    logic          epoch_wrap_reg;
    logic          disc_phase_reg;

    // read data registers
    logic [EW-1:0] head_rd_reg, tail_rd_reg, next_rd_reg, cur_rd_reg;
    logic [7:0]    target_rd_reg, topv_rd_reg, epoch_rd_reg;

    logic accept;
    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {oo_reg, ov_reg};
    assign m_tuser  = kind_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_VERTEX_COUNT) ? {23'd0, vcount_reg} : 32'd0;

    // usable: below vertex_count and below MAX_VERTICES
    function automatic logic usable(input logic [7:0] v, input logic [8:0] vc);
        usable = ({1'b0, v} < vc) && (32'(v) < MAX_VERTICES);
    endfunction

    // ---- memory address muxing ----
    logic [VW-1:0] vaddr;       // head/tail/epoch index
    logic [AW-1:0] eaddr;       // next/target index
    logic [VW-1:0] saddr;       // stack index
    logic [DW-1:0] top_idx;
    assign top_idx = depth_reg - DW'(1);

    always_comb begin
        vaddr = VW'(from_reg);
        eaddr = AW'(cur_reg);
        saddr = VW'(top_idx);
        case (state_reg)
            ST_CLEAR: vaddr = sweep_reg;
            ST_IDLE:  vaddr = VW'(s_tdata[7:0]);
            ST_DISC:  vaddr = VW'(pend_v_reg);
            ST_SEEN:  vaddr = VW'(target_rd_reg);
            ST_EDGE:  vaddr = VW'(target_rd_reg);
            default:  vaddr = VW'(from_reg);
        endcase
    end

    // head / tail / marks
    logic          ht_we, head_we, tail_we;
    logic [EW-1:0] head_wd, tail_wd;
    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[vaddr] <= head_wd;
        end
        if (tail_we) begin
            tail_mem[vaddr] <= tail_wd;
        end
        head_rd_reg  <= head_mem[vaddr];
        tail_rd_reg  <= tail_mem[vaddr];
        epoch_rd_reg <= epoch_mem[vaddr];
        if (ht_we) begin
            epoch_mem[vaddr] <= epoch_reg;
        end
    end

    // edge store
    logic          e_we, n_we;
    logic [AW-1:0] n_addr;
    logic [EW-1:0] n_wd;
    always_ff @(posedge aclk) begin
        if (e_we) begin
            target_mem[AW'(used_reg)] <= to_reg;
        end
        if (n_we) begin
            next_mem[n_addr] <= n_wd;
        end
        next_rd_reg   <= next_mem[eaddr];
        target_rd_reg <= target_mem[eaddr];
    end

    // walk stack
    logic          s_we, c_we;
    logic [VW-1:0] s_waddr;
    logic [EW-1:0] c_wd;
    always_ff @(posedge aclk) begin
        if (s_we) begin
            stk_v_mem[s_waddr] <= pend_v_reg;
        end
        if (c_we) begin
            stk_c_mem[s_waddr] <= c_wd;
        end
        topv_rd_reg <= stk_v_mem[saddr];
        cur_rd_reg  <= stk_c_mem[saddr];
    end

    // ---- sequencer ----
    logic seen;
    assign seen = (epoch_rd_reg == epoch_reg) && !epoch_wrap_reg;

    always_comb begin
        head_we = 1'b0; tail_we = 1'b0; head_wd = LINK_NULL; tail_wd = LINK_NULL;
        ht_we = 1'b0; e_we = 1'b0; n_we = 1'b0; n_addr = AW'(used_reg);
        n_wd = LINK_NULL; s_we = 1'b0; c_we = 1'b0;
        s_waddr = VW'(depth_reg); c_wd = head_rd_reg;
        case (state_reg)
            ST_CLEAR: begin
                head_we = sweep_all_reg; tail_we = sweep_all_reg; ht_we = 1'b1;
            end
            ST_ADD2: begin
                // head/tail of from are valid here
                e_we = 1'b1; n_we = 1'b1;
                tail_we = 1'b1; tail_wd = used_reg;
                if (head_rd_reg == LINK_NULL) begin
                    head_we = 1'b1; head_wd = used_reg;
                end
            end
            ST_HEAD: begin
                // link old tail to the new edge
                n_we = 1'b1; n_addr = AW'(tail_rd_reg); n_wd = EW'(used_reg - EW'(1));
            end
            ST_DISC: begin
                // phase 1: mark the child and push it with its list head
                if (disc_phase_reg) begin
                    ht_we = 1'b1;
                    if (32'(depth_reg) < MAX_VERTICES) begin
                        s_we = 1'b1; c_we = 1'b1;
                    end
                end
            end
            ST_SEEN: begin
                // save the cursor past the chosen edge
                if (!seen && 32'(y_reg) < MAX_VERTICES) begin
                    c_we = 1'b1; s_waddr = VW'(top_idx); c_wd = cur_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            vcount_reg <= 9'd256;
            used_reg <= '0;
            depth_reg <= '0;
            pend_reg <= 1'b0;
            epoch_reg <= 8'd1;
            epoch_wrap_reg <= 1'b1;
            sweep_reg <= '0;
            sweep_all_reg <= 1'b1;
            out_valid_reg <= 1'b0;
            disc_phase_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
                vcount_reg <= (pwdata[8:0] > 9'd256) ? 9'd256 : pwdata[8:0];
            end
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    sweep_reg <= sweep_reg + VW'(1);
                    if (32'(sweep_reg) == MAX_VERTICES - 1) begin
                        state_reg <= ST_IDLE;
                        epoch_wrap_reg <= 1'b0;
                        epoch_reg <= epoch_reg + 8'd1;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        from_reg <= s_tdata[7:0];
                        to_reg   <= s_tdata[15:8];
                        ov_reg <= '0; oo_reg <= '0;
                        case (s_tuser)
                            CMD_ADD: begin
                                if (!usable(s_tdata[7:0], vcount_reg) ||
                                    !usable(s_tdata[15:8], vcount_reg) ||
                                    used_reg == LINK_NULL) begin
                                    kind_reg <= KIND_REJECTED; out_valid_reg <= 1'b1;
                                end else begin
                                    state_reg <= ST_ADD;
                                end
                            end
                            CMD_START: begin
                                if (!usable(s_tdata[7:0], vcount_reg)) begin
                                    kind_reg <= KIND_REJECTED;
                                end else begin
                                    kind_reg <= KIND_ACCEPTED;
                                    depth_reg <= '0;
                                    pend_reg <= 1'b1;
                                    pend_v_reg <= s_tdata[7:0];
                                    // new epoch clears all marks; on wrap, sweep marks
                                    epoch_reg <= epoch_reg + 8'd1;
                                    if (epoch_reg == 8'hFF) begin
                                        state_reg <= ST_CLEAR;
                                        epoch_wrap_reg <= 1'b1;
                                        sweep_reg <= '0;
                                        sweep_all_reg <= 1'b0;
                                    end
                                end
                                out_valid_reg <= 1'b1;
                            end
                            CMD_STEP: begin
                                if (pend_reg) begin
                                    state_reg <= ST_DISC;
                                    disc_phase_reg <= 1'b0;
                                end else if (depth_reg == '0) begin
                                    kind_reg <= KIND_DONE; out_valid_reg <= 1'b1;
                                end else begin
                                    state_reg <= ST_TOP;
                                end
                            end
                            default: begin
                                used_reg <= '0; depth_reg <= '0; pend_reg <= 1'b0;
                                epoch_wrap_reg <= 1'b1; sweep_reg <= '0;
                                sweep_all_reg <= 1'b1; epoch_reg <= '0;
                                kind_reg <= KIND_ACCEPTED; out_valid_reg <= 1'b1;
                                state_reg <= ST_CLEAR;
                            end
                        endcase
                    end
                end
                ST_ADD: state_reg <= ST_ADD2;
                ST_ADD2: begin
                    used_reg <= used_reg + EW'(1);
                    if (head_rd_reg != LINK_NULL) begin
                        state_reg <= ST_HEAD;
                    end else begin
                        kind_reg <= KIND_ACCEPTED; out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_HEAD: begin
                    kind_reg <= KIND_ACCEPTED; out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_DISC: begin
                    // phase 0: read head; phase 1: push and mark
                    if (!disc_phase_reg) begin
                        disc_phase_reg <= 1'b1;
                    end else begin
                        pend_reg <= 1'b0;
                        if (32'(depth_reg) < MAX_VERTICES) begin
                            depth_reg <= depth_reg + DW'(1);
                        end
                        kind_reg <= KIND_DISCOVERED; ov_reg <= pend_v_reg;
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_TOP: begin
                    // stack read issued last cycle lands now
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    top_v_reg <= topv_rd_reg;
                    cur_reg <= cur_rd_reg;
                    state_reg <= ST_EDGE;
                    disc_phase_reg <= 1'b0;
                end
                ST_EDGE: begin
                    // phase 0: edge read in flight; phase 1: target/next valid
                    if (cur_reg == LINK_NULL) begin
                        depth_reg <= top_idx;
                        kind_reg <= KIND_FINISHED; ov_reg <= top_v_reg;
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else if (!disc_phase_reg) begin
                        disc_phase_reg <= 1'b1;
                    end else begin
                        y_reg <= target_rd_reg;
                        cur_reg <= next_rd_reg;
                        disc_phase_reg <= 1'b0;
                        state_reg <= ST_SEEN;
                    end
                end
                ST_SEEN: begin
                    // epoch of target read in ST_EDGE's last cycle
                    if (!seen && 32'(y_reg) < MAX_VERTICES) begin
                        pend_reg <= 1'b1; pend_v_reg <= y_reg;
                        kind_reg <= KIND_TREE_EDGE; ov_reg <= y_reg; oo_reg <= top_v_reg;
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_EDGE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---- assertions ----
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("beat accepted while sequencer busy");
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(depth_reg) <= MAX_VERTICES)
        else $error("walk stack overflow");
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= LINK_NULL)
        else $error("edge count beyond table");
    a_tree_sets_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEEN && $past(state_reg) == ST_EDGE) |-> !pend_reg)
        else $error("edge scan with pending child");

endmodule
